// File: rtl/lbp_pkg.sv
// Shared types, constants and the pattern function of the 3x3 LBP stream block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lbp_pkg;

  localparam int PixW       = 8;
  localparam int CfgWidthW  = 11;
  localparam int CfgHeightW = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 1;
  // The row counter runs one row past a full-height image while codes drain.
  localparam int RowW       = 17;
  localparam int OutIdxW    = 27;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'd1;

  localparam logic ActPixel = 1'b0;
  localparam logic ActFlush = 1'b1;

  typedef logic [PixW-1:0] pixel_t;

  // One window column, index 0 is the top row.
  typedef pixel_t [2:0] col3_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic adv;       // take one pixel into the window
    logic clear;     // restart the image
    logic col_zero;  // the item sits in column 0
    logic col_ge2;   // the item sits in column 2 or later
    logic wide;      // the image is at least two pixels wide
  } win_ctrl_t;

  // Bit 7 down to 0: top-left, left, bottom-left, bottom, bottom-right,
  // right, top-right, top. A bit is set when the neighbor is not below
  // the center.
  function automatic logic [7:0] lbp_pattern(col3_t l, col3_t m, col3_t r);
    pixel_t [7:0] nb;
    logic   [7:0] code;
    nb[7] = l[0];
    nb[6] = l[1];
    nb[5] = l[2];
    nb[4] = m[2];
    nb[3] = r[2];
    nb[2] = r[1];
    nb[1] = r[0];
    nb[0] = m[0];
    for (int k = 0; k < 8; k++) begin
      code[k] = (nb[k] >= m[1]);
    end
    return code;
  endfunction

endpackage

// File: rtl/lbp_in_if.sv
// Input channel of the LBP stream block: valid/ready handshake with one pixel word.
// Depends on lbp_pkg for the pixel type.
`timescale 1ns / 1ps

interface lbp_in_if import lbp_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   action;
  pixel_t pixel;

  modport source (output valid, output action, output pixel, input ready);
  modport sink   (input valid, input action, input pixel, output ready);
endinterface

// File: rtl/lbp_out_if.sv
// Output channel of the LBP stream block: valid/ready handshake with one code word.
// Imports lbp_pkg; the eight-bit code width is written out here directly.
`timescale 1ns / 1ps

interface lbp_out_if import lbp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] code;
  logic       last;

  modport source (output valid, output code, output last, input ready);
  modport sink   (input valid, input code, input last, output ready);
endinterface

// File: rtl/lbp_linestore.sv
// Two line memories (upper and middle row) with registered reads and write bypass.
// Depends on lbp_pkg for the pixel type.
`timescale 1ns / 1ps

module lbp_linestore import lbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   we_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr_i,
  input  pixel_t                                 wr_upper_i,
  input  pixel_t                                 wr_middle_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr_i,
  output pixel_t                                 upper_o,
  output pixel_t                                 middle_o
);

  pixel_t upper_mem  [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];

  pixel_t upper_rd_q, middle_rd_q;
  pixel_t byp_upper_q, byp_middle_q;
  logic   byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      upper_mem[wr_addr_i]  <= wr_upper_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
    upper_rd_q   <= upper_mem[rd_addr_i];
    middle_rd_q  <= middle_mem[rd_addr_i];
    byp_upper_q  <= wr_upper_i;
    byp_middle_q <= wr_middle_i;
  end

  // A write to the address being read in the same cycle must win over the
  // old memory contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign upper_o  = byp_q ? byp_upper_q  : upper_rd_q;
  assign middle_o = byp_q ? byp_middle_q : middle_rd_q;

endmodule

// File: rtl/lbp_window.sv
// 3x3 pixel window registers and the code of the pixel that the current step completes.
// Depends on lbp_pkg for the column type, control struct and pattern function.
`timescale 1ns / 1ps

module lbp_window import lbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  win_ctrl_t  ctrl_i,
  input  pixel_t     v_i,
  input  pixel_t     up_i,
  input  pixel_t     mid_i,
  output logic [7:0] code_o
);

  col3_t [2:0] win_q, win_d, win_new;
  col3_t       new_col;
  col3_t       zero_col;
  logic [7:0]  code_row_end, code_inner;

  always_comb begin
    zero_col   = '0;
    new_col[0] = up_i;
    new_col[1] = mid_i;
    new_col[2] = v_i;
    win_new[0] = win_q[1];
    win_new[1] = win_q[2];
    win_new[2] = new_col;
  end

  // In column 0 the step finishes the last pixel of an earlier row, whose
  // right neighbors lie outside the image.
  assign code_row_end = lbp_pattern(ctrl_i.wide ? win_q[1] : zero_col, win_q[2], zero_col);
  assign code_inner   = lbp_pattern(ctrl_i.col_ge2 ? win_new[0] : zero_col,
                                    win_new[1], win_new[2]);
  assign code_o       = ctrl_i.col_zero ? code_row_end : code_inner;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.adv) begin
      win_d = win_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule

// File: rtl/lbp_outbuf.sv
// Two-entry output buffer that decouples the code channel from the pixel channel.
// Depends on lbp_pkg for the result type and on lbp_out_if.
`timescale 1ns / 1ps

module lbp_outbuf import lbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  result_t          push_data_i,
  output logic             full_o,
  lbp_out_if.source        code_o
);

  result_t    buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop          = code_o.valid && code_o.ready;
  assign code_o.valid = (count_q != 2'd0);
  assign code_o.code  = buf_q[rd_ptr_q].code;
  assign code_o.last  = buf_q[rd_ptr_q].last;
  assign full_o       = (count_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/lbp_3x3_stream.sv
// The code of a pixel is computed by the item that arrives image_width+1 words later and
// sits in the output buffer in the cycle after that item; flush words drain the rest.
// One word per cycle while the output buffer is not full; line memories are read ahead at
// the next column. A one-row image takes an idle step after its last pixel. Reset clears
// counters, window and buffer at once; no memory clearing pass.
`timescale 1ns / 1ps

module lbp_3x3_stream import lbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  lbp_in_if.sink               pix_i,
  lbp_out_if.source            code_o
);

  localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration registers.
  logic [CfgWidthW-1:0]  cfg_width_q;
  logic [CfgHeightW-1:0] cfg_height_q;

  // Stream position of the next word and the index of the next code.
  logic [AddrW-1:0]   col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [OutIdxW-1:0] out_idx_q, out_idx_d;

  logic [CfgWidthW-1:0]  eff_w;
  logic [CfgHeightW-1:0] eff_h;
  logic [OutIdxW-1:0]    total;

  logic      in_image, silent, full, in_ready, accept, adv, emit, last;
  logic      cfg_clear, clear, col_zero, row_ge1, row_ge2, col_wrap;
  pixel_t    v, up, mid, ls_upper, ls_middle;
  logic [7:0] code;
  win_ctrl_t win_ctrl;
  result_t   result;

  // A width of zero acts as one and a width beyond the line memory acts as
  // its depth; a height of zero acts as one.
  always_comb begin
    if (cfg_width_q == '0) begin
      eff_w = CfgWidthW'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = CfgWidthW'(MAX_WIDTH);
    end else begin
      eff_w = cfg_width_q;
    end
    eff_h = (cfg_height_q == '0) ? CfgHeightW'(1) : cfg_height_q;
  end

  assign total = OutIdxW'(eff_w) * OutIdxW'(eff_h);

  assign in_image = (row_q < RowW'(eff_h));
  assign col_zero = (col_q == '0);
  assign row_ge1  = (row_q >= RowW'(1));
  assign row_ge2  = (row_q >= RowW'(2));

  // In a one-row image the first step past the image only shifts the window
  // and yields nothing. It is taken on its own in an idle cycle, so that every
  // later flush word yields exactly one code.
  assign silent = !in_image && (row_q == RowW'(1)) && col_zero;

  assign in_ready    = !full && !silent;
  assign pix_i.ready = in_ready;
  assign accept      = pix_i.valid && in_ready;

  // A flush word inside the image is dropped; any word past the image acts
  // as a flush, whatever its pixel value.
  assign adv = silent || (accept && (!in_image || (pix_i.action == ActPixel)));
  assign v   = (in_image && !silent) ? pix_i.pixel : '0;

  // Rows above the image read as zero, so a line memory entry is only used
  // after this image has written it.
  assign up  = row_ge2 ? ls_upper  : '0;
  assign mid = row_ge1 ? ls_middle : '0;

  assign emit = adv && ((col_zero && row_ge2) || (!col_zero && row_ge1));
  assign last = ((out_idx_q + OutIdxW'(1)) == total);

  assign cfg_clear = cfg_we_i &&
                     ((cfg_idx_i == RegImageWidth) || (cfg_idx_i == RegImageHeight));
  assign clear     = cfg_clear || (emit && last);

  assign col_wrap = ((32'(col_q) + 32'd1) >= 32'(eff_w));

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    out_idx_d = out_idx_q;
    if (clear) begin
      col_d     = '0;
      row_d     = '0;
      out_idx_d = '0;
    end else if (adv) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + AddrW'(1);
      end
      if (emit) begin
        out_idx_d = out_idx_q + OutIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CfgWidthW'(1024);
      cfg_height_q <= CfgHeightW'(1);
      col_q        <= '0;
      row_q        <= '0;
      out_idx_q    <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == RegImageWidth)) begin
        cfg_width_q <= cfg_data_i[CfgWidthW-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == RegImageHeight)) begin
        cfg_height_q <= cfg_data_i[CfgHeightW-1:0];
      end
      col_q     <= col_d;
      row_q     <= row_d;
      out_idx_q <= out_idx_d;
    end
  end

  // The memories are read at the next column, so the data of the current
  // column is ready when its word arrives.
  lbp_linestore #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linestore (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (adv),
    .wr_addr_i   (col_q),
    .wr_upper_i  (mid),
    .wr_middle_i (v),
    .rd_addr_i   (col_d),
    .upper_o     (ls_upper),
    .middle_o    (ls_middle)
  );

  always_comb begin
    win_ctrl.adv      = adv;
    win_ctrl.clear    = clear;
    win_ctrl.col_zero = col_zero;
    win_ctrl.col_ge2  = (32'(col_q) >= 32'd2);
    win_ctrl.wide     = (eff_w >= CfgWidthW'(2));
  end

  lbp_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .v_i    (v),
    .up_i   (up),
    .mid_i  (mid),
    .code_o (code)
  );

  assign result.code = code;
  assign result.last = last;

  lbp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_data_i (result),
    .full_o      (full),
    .code_o      (code_o)
  );

  // A code is never produced while the output buffer is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> !full)
    else $error("code produced into a full output buffer");

  // After the final code of an image the stream restarts from the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last && !cfg_clear) |=> (col_q == '0) && (row_q == '0) && (out_idx_q == '0))
    else $error("stream not restarted after the final code");

  // The column counter stays inside the configured row.
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(col_q) < 32'(eff_w))
    else $error("column counter beyond the image width");

  // The internal shift step only occurs in one-row images and never emits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    silent |-> (eff_h == CfgHeightW'(1)) && !emit)
    else $error("internal step outside a one-row image");

endmodule

// File: test/lbp_3x3_stream_tb.sv
// Self-checking testbench for lbp_3x3_stream: random and directed pixel streams against a
// cycle-free predictor of the 3x3 local binary pattern codes, with random stalls on both sides.
// Depends on lbp_pkg, lbp_in_if, lbp_out_if and the lbp_3x3_stream RTL.
`timescale 1ns / 1ps

module lbp_3x3_stream_tb;
  import lbp_pkg::*;

  localparam int          LineDepth   = 1024;
  localparam int unsigned RandomWords = 250;
  // The limit leaves a wide margin over the length of a correct run.
  localparam int unsigned CycleLimit  = 1_000_000;

  // Predicts the code words of the block from the accepted input words and
  // compares them, in order, with the code words that come out.
  class code_scoreboard;
    pixel_t      upper_row [LineDepth];
    pixel_t      middle_row[LineDepth];
    col3_t       win[3];            // window columns, 0 is the leftmost
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned codes_out;
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned images_done;
    int unsigned mismatches;
    result_t     expected_codes[$];

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      width_reg   = LineDepth;
      height_reg  = 1;
      images_done = 0;
      mismatches  = 0;
      restart();
    endfunction

    function void restart();
      foreach (win[i]) win[i] = '0;
      col_pos   = 0;
      row_pos   = 0;
      codes_out = 0;
    endfunction

    // A width of zero behaves as one, and anything past the line depth as the depth.
    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > LineDepth) return LineDepth;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegImageWidth:  width_reg  = data[CfgWidthW-1:0];
        RegImageHeight: height_reg = data[CfgHeightW-1:0];
        default: ;
      endcase
      restart();
    endfunction

    // Neighbors go counterclockwise from the top-left corner; a neighbor that is not
    // below the center sets its bit, the top-left one being bit 7.
    function logic [7:0] neighbor_code(col3_t lft, col3_t mid, col3_t rgt);
      pixel_t     ring[8];
      logic [7:0] code;
      ring[0] = lft[0];
      ring[1] = lft[1];
      ring[2] = lft[2];
      ring[3] = mid[2];
      ring[4] = rgt[2];
      ring[5] = rgt[1];
      ring[6] = rgt[0];
      ring[7] = mid[0];
      for (int k = 0; k < 8; k++) code[7-k] = (ring[k] >= mid[1]);
      return code;
    endfunction

    // Moves one pixel (real or zero) into the window at the current position.
    function void shift_in(pixel_t px, output logic [7:0] code, output bit got);
      int unsigned w;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      bit          primed;
      pixel_t      up;
      pixel_t      mid;
      w      = eff_width();
      c      = col_pos;
      r      = row_pos;
      idx    = (c < LineDepth) ? c : 0;
      primed = (r * w + c >= w + 1);
      got    = 1'b0;
      code   = '0;
      // In column 0 the window still holds the end of an older row, whose
      // last pixel is now complete.
      if (c == 0 && primed) begin
        code = neighbor_code((w >= 2) ? win[1] : col3_t'(0), win[2], col3_t'(0));
        got  = 1'b1;
      end
      up  = (r >= 2) ? upper_row[idx]  : pixel_t'(0);
      mid = (r >= 1) ? middle_row[idx] : pixel_t'(0);
      upper_row[idx]  = mid;
      middle_row[idx] = px;
      win[0] = win[1];
      win[1] = win[2];
      win[2] = {px, mid, up};
      if (c >= 1 && primed) begin
        code = neighbor_code((c >= 2) ? win[0] : col3_t'(0), win[1], win[2]);
        got  = 1'b1;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    function void take_word(logic act, pixel_t px);
      int unsigned w;
      int unsigned h;
      logic [7:0]  code;
      bit          got;
      result_t     res;
      w = eff_width();
      h = eff_height();
      if (row_pos < h) begin
        if (act == ActFlush) return;
        shift_in(px, code, got);
      end else begin
        // A one-row image needs an extra step on its first flush.
        if (row_pos * w + col_pos < w + 1) shift_in('0, code, got);
        shift_in('0, code, got);
      end
      if (!got) return;
      res.code = code;
      res.last = (codes_out + 1 == w * h);
      expected_codes.push_back(res);
      codes_out++;
      if (res.last) begin
        images_done++;
        restart();
      end
    endfunction

    function void check_word(logic [7:0] code, logic last);
      result_t want;
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected code word %02h last %0d with nothing expected", code, last);
        return;
      end
      want = expected_codes.pop_front();
      if (want.code !== code || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("code word mismatch: expected %02h last %0d, got %02h last %0d",
                   want.code, want.last, code, last);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lbp_in_if  pix_if ();
  lbp_out_if code_if ();

  lbp_3x3_stream #(
    .MAX_WIDTH(LineDepth)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix_if.sink),
    .code_o    (code_if.source)
  );

  code_scoreboard sb = new();

  int unsigned cycle_count    = 0;
  int unsigned hold_request   = 0;  // cycles the code sink must hold off, set by the stimulus
  int unsigned words_streamed = 0;  // pixel and drain words, without ignored flushes
  bit          tx_fast        = 1'b0;  // sender sends without gaps
  bit          rx_fast        = 1'b0;  // receiver takes without stalls

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Code sink. Every accepted word is checked; after it the sink draws a
  // random stall, or none at all during its fast stretches. A hold request
  // from the stimulus replaces the stall with a long one, counted
  // down here one cycle at a time. The ready value is written once per edge.
  initial begin : code_sink
    int unsigned stall_left;
    int unsigned taken;
    stall_left = 0;
    taken      = 0;
    code_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (code_if.valid && code_if.ready) begin
        sb.check_word(code_if.code, code_if.last);
        taken++;
        if (taken % 64 == 0) rx_fast = ($urandom_range(0, 2) == 0);
        stall_left = rx_fast ? 0 : $urandom_range(0, 9);
      end
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      code_if.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Offers one word after a random gap and returns at the edge that accepts
  // it. Valid stays high when the next word follows with no gap, so it is
  // only lowered at the start of a gap.
  task automatic send_word(logic act, pixel_t px);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid  <= 1'b1;
    pix_if.action <= act;
    pix_if.pixel  <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    sb.take_word(act, px);
  endtask

  // Stops sending and waits until every expected code word has come out,
  // then waits on for words still moving through the block that give no
  // code. It always waits past the edge at which valid is lowered.
  task automatic settle();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_codes.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Writing either register restarts the image, so this is only called
  // while the block is idle.
  task automatic configure(logic [CfgDataW-1:0] width, logic [CfgDataW-1:0] height);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegImageWidth;
    cfg_data_i <= width;
    @(posedge clk_i);
    cfg_idx_i  <= RegImageHeight;
    cfg_data_i <= height;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(RegImageWidth, width);
    sb.write_reg(RegImageHeight, height);
  endtask

  // Value styles: full range, only the extremes, and two narrow bands that
  // make neighbors equal to the center often.
  function automatic pixel_t draw_pixel(int unsigned style);
    case (style)
      0:       return pixel_t'($urandom);
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return pixel_t'($urandom_range(100, 103));
      default: return pixel_t'($urandom_range(0, 3));
    endcase
  endfunction

  // Sends flush words, with some pixel words mixed in that act as flushes,
  // until the code of the final pixel has been predicted.
  task automatic drain_image();
    int unsigned done_mark;
    done_mark = sb.images_done;
    while (sb.images_done == done_mark) begin
      send_word(($urandom_range(0, 3) == 0) ? ActPixel : ActFlush, pixel_t'($urandom));
      words_streamed++;
    end
  endtask

  // Sends the pixels of an image, with stray flushes that the block must
  // ignore and optionally one pause until all pending codes are out.
  task automatic stream_image(int unsigned pixels, bit noisy, bit pause_once, bit drain);
    int unsigned style;
    int unsigned pause_at;
    style    = $urandom_range(0, 3);
    pause_at = $urandom_range(0, pixels - 1);
    for (int unsigned i = 0; i < pixels; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_word(ActFlush, pixel_t'($urandom));
      if (pause_once && i == pause_at) settle();
      send_word(ActPixel, draw_pixel(style));
      words_streamed++;
    end
    if (drain) drain_image();
  endtask

  initial begin : stimulus
    pixel_t              cross_px[9];
    int unsigned         random_start;
    int unsigned         w;
    int unsigned         h;
    logic [CfgDataW-1:0] w_data;
    cross_px = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00};

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= RegImageWidth;
    cfg_data_i    <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.action <= ActPixel;
    pix_if.pixel  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset settings give one full-width row, so a short stream with
    // stray flushes yields no code before the next register write restarts
    // the image.
    stream_image(24, 1'b1, 1'b0, 1'b0);
    settle();

    // Single-pixel image: an early flush is ignored, a pixel past the end
    // drains like a flush, and the next pixel opens a fresh image.
    configure(16'd1, 16'd1);
    send_word(ActFlush, 8'h5A);
    send_word(ActPixel, 8'h00);
    send_word(ActPixel, 8'd77);
    send_word(ActPixel, 8'hFF);
    send_word(ActFlush, 8'h00);
    settle();

    // A 3x3 checker of the extremes with a mid-gray center.
    configure(16'd3, 16'd3);
    foreach (cross_px[i]) send_word(ActPixel, cross_px[i]);
    drain_image();
    settle();

    // Zero width and zero height both behave as one.
    configure(16'd0, 16'd0);
    send_word(ActPixel, 8'd200);
    send_word(ActFlush, 8'd0);
    settle();

    // A two-pixel row of equal values.
    configure(16'd2, 16'd1);
    send_word(ActPixel, 8'd9);
    send_word(ActPixel, 8'd9);
    drain_image();
    settle();

    // A width past the line depth acts as the full depth. The first row is
    // sent whole, so codes only appear once the column wraps at the line depth
    // and the second row reads back the start of the first; the rest of the
    // image is dropped by the next register write.
    configure(16'd2047, 16'd3);
    stream_image(LineDepth + 12, 1'b0, 1'b0, 1'b0);
    settle();

    // Back pressure: the sink holds off for a long stretch while the source
    // keeps offering words, so the block fills up and stalls its input.
    configure(16'd16, 16'd6);
    tx_fast      = 1'b1;
    hold_request = 400;
    stream_image(96, 1'b0, 1'b0, 1'b1);
    settle();

    // Random part: mostly complete images of small sizes, sometimes several
    // in a row on one setting, with noise flushes and pauses mixed in.
    random_start = words_streamed;
    while (words_streamed < random_start + RandomWords) begin
      settle();
      tx_fast = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       w = 0;
        7, 8:    w = $urandom_range(9, 40);
        default: w = $urandom_range(1, 8);
      endcase
      w_data = CfgDataW'(w);
      // Bits above the width field must have no effect.
      if ($urandom_range(0, 3) == 0)
        w_data = w_data | (CfgDataW'($urandom_range(0, 31)) << CfgWidthW);
      if ($urandom_range(0, 11) == 0) begin
        // Tallest image: only its top rows are sent before the next write.
        configure(w_data, 16'hFFFF);
        stream_image(sb.eff_width() * $urandom_range(2, 8), 1'b1,
                     $urandom_range(0, 3) == 0, 1'b0);
      end else begin
        h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
        configure(w_data, CfgDataW'(h));
        repeat ($urandom_range(1, 3))
          stream_image(sb.eff_width() * sb.eff_height(), 1'b1,
                       $urandom_range(0, 3) == 0, 1'b1);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_codes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: lbp_3x3_stream.f
rtl/lbp_pkg.sv
rtl/lbp_in_if.sv
rtl/lbp_out_if.sv
rtl/lbp_linestore.sv
rtl/lbp_window.sv
rtl/lbp_outbuf.sv
rtl/lbp_3x3_stream.sv
test/lbp_3x3_stream_tb.sv
